// ===== sv/lbcc_pkg.sv =====
// lbcc_pkg: shared constants, types and helpers for the block cache directory
package lbcc_pkg;

    localparam int CACHE_SLOTS       = 16;
    localparam int SECTORS_PER_BLOCK = 8;

    localparam int TAG_W    = 32;
    localparam int SECTOR_W = 35;
    localparam int OP_W     = 2;
    localparam int SLOT_OUT_W = 4;
    localparam int SLOT_W   = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    localparam int RANK_W   = SLOT_W;
    // one extra bit so that a free slot can stand for "older than everything"
    localparam int ORANK_W  = RANK_W + 1;
    localparam int SPB_W    = $clog2(SECTORS_PER_BLOCK + 1);
    localparam int PROD_W   = TAG_W + SPB_W;

    // opcodes
    localparam logic [OP_W-1:0] OP_READ       = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_FULL = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE_PART = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } lbcc_state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic [TAG_W-1:0]   key;
        logic               wr;
        logic               hit;
        logic [ORANK_W-1:0] old_rank;
    } lbcc_cmd_t;

    // data handed from one cell to the next along the row
    typedef struct packed {
        logic               used;
        logic               match;
        logic               sel;
        logic [ORANK_W-1:0] rank;
        logic [TAG_W-1:0]   tag;
        logic               dirty;
        logic [SLOT_W-1:0]  index;
    } lbcc_chain_t;

    // block number to disk sector address, low bits kept
    function automatic logic [SECTOR_W-1:0] sector_of(input logic [TAG_W-1:0] blk);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(blk) * PROD_W'(SECTORS_PER_BLOCK);
        return SECTOR_W'(prod);
    endfunction

endpackage

// ===== sv/lbcc_cell.sv =====
// lbcc_cell: one directory slot holding tag, in-use, dirty and recency rank
module lbcc_cell
    import lbcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] idx,
    input  logic              lookup_en,
    input  logic              update_en,
    input  lbcc_cmd_t         cmd,
    input  lbcc_chain_t       chain_in,
    output lbcc_chain_t       chain_out
);

    logic               used_reg;
    logic               dirty_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [RANK_W-1:0]  rank_reg;
    logic               match_reg;
    logic               cand_reg;

    logic               match_now;
    logic               free_now;
    logic               lru_now;
    logic               sel;
    logic [ORANK_W-1:0] my_rank;
    logic               ages;

    // local lookup flags
    always_comb
    begin
        match_now = used_reg && (tag_reg == cmd.key);
        free_now  = !used_reg && chain_in.used;
        lru_now   = used_reg && (rank_reg == RANK_W'(CACHE_SLOTS - 1));
        sel       = match_reg || (!cmd.hit && cand_reg);
        my_rank   = used_reg ? {1'b0, rank_reg} : ORANK_W'(CACHE_SLOTS);
        ages      = used_reg && ({1'b0, rank_reg} < cmd.old_rank);
    end

    // pass accumulated selection down the row
    always_comb
    begin
        chain_out.used  = used_reg;
        chain_out.match = chain_in.match | match_now;
        chain_out.sel   = chain_in.sel | sel;
        chain_out.rank  = chain_in.rank | (sel ? my_rank : '0);
        chain_out.tag   = chain_in.tag | (sel ? tag_reg : '0);
        chain_out.dirty = chain_in.dirty | (sel && used_reg && dirty_reg);
        chain_out.index = chain_in.index | (sel ? idx : '0);
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            dirty_reg <= 1'b0;
            match_reg <= 1'b0;
            cand_reg  <= 1'b0;
        end
        else
        begin
            if (lookup_en)
            begin
                match_reg <= match_now;
                cand_reg  <= free_now || lru_now;
            end
            if (update_en && sel)
            begin
                used_reg  <= 1'b1;
                dirty_reg <= (match_reg && dirty_reg) || cmd.wr;
            end
        end
    end

    // tag and recency rank
    always_ff @(posedge clk)
    begin
        if (update_en)
        begin
            if (sel)
            begin
                tag_reg  <= cmd.key;
                rank_reg <= '0;
            end
            else if (ages)
            begin
                rank_reg <= rank_reg + RANK_W'(1);
            end
        end
    end

endmodule

// ===== sv/lru_block_cache_controller_core.sv =====
// lru_block_cache_controller_core: top level of the lru block cache directory
// a transaction accepted while not busy passes through the lookup and update states before its result strobe
// busy is high for the lookup cycle only; a new start is also taken in the update state
// the cycle after a lookup updates the row of slot cells and takes the next start
// reset: asynchronous active low; all slots free and clean, no result pending
// results appear on done for one cycle and are never held back
module lru_block_cache_controller_core
    import lbcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [TAG_W-1:0]      block_number,
    input  logic [OP_W-1:0]       opcode,
    output logic                  done,
    output logic                  hit,
    output logic [SLOT_OUT_W-1:0] slot,
    output logic                  fill_needed,
    output logic [SECTOR_W-1:0]   fill_sector,
    output logic                  writeback_needed,
    output logic [SECTOR_W-1:0]   writeback_sector
);

    lbcc_state_t state_reg, state_next;

    logic [TAG_W-1:0] key_reg;
    logic             wr_reg;
    logic             fill_op_reg;
    logic             lookup_hit_reg;

    logic                  done_reg;
    logic                  hit_reg;
    logic [SLOT_OUT_W-1:0] slot_reg;
    logic                  fill_needed_reg;
    logic [SECTOR_W-1:0]   fill_sector_reg;
    logic                  writeback_needed_reg;
    logic [SECTOR_W-1:0]   writeback_sector_reg;

    logic        accept;
    logic        lookup_en;
    logic        update_en;
    lbcc_cmd_t   cmd;
    lbcc_chain_t chain [CACHE_SLOTS+1];
    lbcc_chain_t chain_end;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   state_next = start ? ST_LOOKUP : ST_IDLE;
            ST_LOOKUP: state_next = ST_UPDATE;
            ST_UPDATE: state_next = start ? ST_LOOKUP : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // state decodes
    always_comb
    begin
        busy      = 1'b0;
        lookup_en = 1'b0;
        update_en = 1'b0;
        unique case (state_reg)
            ST_IDLE:   busy = 1'b0;
            ST_LOOKUP:
            begin
                busy      = 1'b1;
                lookup_en = 1'b1;
            end
            ST_UPDATE: update_en = 1'b1;
            default:   busy = 1'b0;
        endcase
    end

    assign accept = start && !busy;

    // broadcast to the cells
    always_comb
    begin
        cmd.key      = key_reg;
        cmd.wr       = wr_reg;
        cmd.hit      = lookup_hit_reg;
        cmd.old_rank = chain_end.rank;
    end

    // row of slot cells
    assign chain[0] = '{used: 1'b1, match: 1'b0, sel: 1'b0, rank: '0, tag: '0,
                        dirty: 1'b0, index: '0};

    for (genvar g = 0; g < CACHE_SLOTS; g++)
    begin : g_cell
        lbcc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (SLOT_W'(g)),
            .lookup_en (lookup_en),
            .update_en (update_en),
            .cmd       (cmd),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1])
        );
    end

    assign chain_end = chain[CACHE_SLOTS];

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            done_reg       <= 1'b0;
            lookup_hit_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= update_en;
            if (lookup_en)
            begin
                lookup_hit_reg <= chain_end.match;
            end
        end
    end

    // transaction payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg     <= block_number;
            wr_reg      <= (opcode == OP_WRITE_FULL) || (opcode == OP_WRITE_PART);
            fill_op_reg <= (opcode != OP_WRITE_FULL);
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (update_en)
        begin
            hit_reg              <= lookup_hit_reg;
            slot_reg             <= SLOT_OUT_W'(chain_end.index);
            fill_needed_reg      <= !lookup_hit_reg && fill_op_reg;
            fill_sector_reg      <= sector_of(key_reg);
            writeback_needed_reg <= !lookup_hit_reg && chain_end.dirty;
            writeback_sector_reg <= (!lookup_hit_reg && chain_end.dirty)
                                    ? sector_of(chain_end.tag) : '0;
        end
    end

    assign done             = done_reg;
    assign hit              = hit_reg;
    assign slot             = slot_reg;
    assign fill_needed      = fill_needed_reg;
    assign fill_sector      = fill_sector_reg;
    assign writeback_needed = writeback_needed_reg;
    assign writeback_sector = writeback_sector_reg;

`ifndef SYNTHESIS
    // a lookup only follows an accepted transaction
    a_lookup_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOOKUP |-> $past(start && !busy))
        else $error("lookup without accepted transaction");

    // a result only follows an update cycle
    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_UPDATE))
        else $error("result strobe without update");

    // a hit never evicts
    a_no_wb_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> !writeback_needed)
        else $error("writeback reported on a hit");

    // a hit never needs a fill
    a_no_fill_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> !fill_needed)
        else $error("fill reported on a hit");

    // at least one cell is chosen during an update
    a_one_selected: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPDATE |-> chain_end.sel)
        else $error("no slot selected for update");
`endif

endmodule
